>>> src/line_rasterizer_assert.svh
// Assertion macros shared by the line rasterizer RTL.
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lr_pkg.sv
// Package with the opcode and octant codes of the line rasterizer.
package lr_pkg;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    OCT_0 = 3'd0,
    OCT_1 = 3'd1,
    OCT_2 = 3'd2,
    OCT_3 = 3'd3,
    OCT_4 = 3'd4,
    OCT_5 = 3'd5,
    OCT_6 = 3'd6,
    OCT_7 = 3'd7
  } octant_e;

endpackage

>>> src/lr_if.sv
// Request and pixel channel interfaces of the line rasterizer.
interface lr_req_if #(
  parameter int unsigned COORD_BITS = 11
);
  logic                  valid;
  logic                  ready;
  logic [0:0]            opcode;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, opcode, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lr_pix_if #(
  parameter int unsigned COORD_BITS = 11
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last;

  modport source (output valid, pixel_x, pixel_y, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, last, output ready);
endinterface

>>> src/lr_setup.sv
// Octant classification, folding and decision setup for a new line.
module lr_setup #(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic [COORD_BITS-1:0]     start_x_i,
  input  logic [COORD_BITS-1:0]     start_y_i,
  input  logic [COORD_BITS-1:0]     end_x_i,
  input  logic [COORD_BITS-1:0]     end_y_i,
  output lr_pkg::octant_e           octant_o,
  output logic signed [COORD_BITS:0]   major_pos_o,
  output logic signed [COORD_BITS:0]   major_end_o,
  output logic signed [COORD_BITS:0]   minor_pos_o,
  output logic signed [COORD_BITS:0]   delta_major_o,
  output logic signed [COORD_BITS:0]   delta_minor_o,
  output logic signed [COORD_BITS+2:0] decision_o,
  output logic                      active_o
);
  import lr_pkg::*;

  localparam int unsigned PW = COORD_BITS + 1;
  localparam int unsigned DW = COORD_BITS + 3;

  logic signed [PW-1:0] x0, y0, x1, y1;
  logic signed [PW-1:0] dx, dy, ndx, ndy;
  logic [COORD_BITS-1:0] adx, ady;
  logic                  steep;
  octant_e               oct;
  logic signed [PW-1:0] minor_end;
  logic signed [PW-1:0] dmaj, dmin;

  function automatic logic signed [2*PW-1:0] fold(octant_e o, logic signed [PW-1:0] x,
                                                  logic signed [PW-1:0] y);
    logic signed [PW-1:0] maj;
    logic signed [PW-1:0] mnr;
    case (o)
      OCT_0: begin maj = x;  mnr = y;  end
      OCT_1: begin maj = y;  mnr = x;  end
      OCT_2: begin maj = y;  mnr = -x; end
      OCT_3: begin maj = -x; mnr = y;  end
      OCT_4: begin maj = -x; mnr = -y; end
      OCT_5: begin maj = -y; mnr = -x; end
      OCT_6: begin maj = -y; mnr = x;  end
      default: begin maj = x; mnr = -y; end
    endcase
    return {maj, mnr};
  endfunction

  always_comb begin
    x0  = $signed({1'b0, start_x_i});
    y0  = $signed({1'b0, start_y_i});
    x1  = $signed({1'b0, end_x_i});
    y1  = $signed({1'b0, end_y_i});
    dx  = x1 - x0;
    dy  = y1 - y0;
    ndx = -dx;
    ndy = -dy;
    adx = dx[PW-1] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ady = dy[PW-1] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    steep = (adx <= ady);

    if (!dx[PW-1] && !dy[PW-1]) begin
      oct = steep ? OCT_1 : OCT_0;
    end else if (dx[PW-1] && !dy[PW-1]) begin
      oct = steep ? OCT_2 : OCT_3;
    end else if (dx[PW-1]) begin
      oct = steep ? OCT_5 : OCT_4;
    end else begin
      oct = steep ? OCT_6 : OCT_7;
    end

    {major_pos_o, minor_pos_o} = fold(oct, x0, y0);
    {major_end_o, minor_end}   = fold(oct, x1, y1);
    dmaj = major_end_o - major_pos_o;
    dmin = minor_end - minor_pos_o;
  end

  assign octant_o      = oct;
  assign delta_major_o = dmaj;
  assign delta_minor_o = dmin;
  assign decision_o    = ($signed({{(DW-PW){dmin[PW-1]}}, dmin}) <<< 1)
                         - $signed({{(DW-PW){dmaj[PW-1]}}, dmaj});
  assign active_o      = (dmaj != '0);

endmodule

>>> src/line_rasterizer.sv
// Top level of the Bresenham line rasterizer with octant folding.
// A request is registered and then processed; a step's pixel is shown on the output
// register. Throughput: one request per cycle while the output register is not
// stalled; the line state update is a loop through the line state registers.
// Reset clears the request and output valid flags and leaves no line in progress.
module line_rasterizer #(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  lr_req_if.sink   req_i,
  lr_pix_if.source pix_o
);
  import lr_pkg::*;

  `include "line_rasterizer_assert.svh"

  localparam int unsigned PW = COORD_BITS + 1;
  localparam int unsigned DW = COORD_BITS + 3;

  // Request register.
  logic                  in_valid_q;
  opcode_e               in_op_q;
  logic [COORD_BITS-1:0] in_sx_q, in_sy_q, in_ex_q, in_ey_q;

  // Line state.
  octant_e              octant_q;
  logic signed [PW-1:0] major_pos_q, major_end_q, minor_pos_q;
  logic signed [PW-1:0] delta_major_q, delta_minor_q;
  logic signed [DW-1:0] decision_q;
  logic                 active_q;

  // Output register.
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic                  out_last_q;

  // Setup results.
  octant_e              su_oct;
  logic signed [PW-1:0] su_maj_pos, su_maj_end, su_min_pos, su_dmaj, su_dmin;
  logic signed [DW-1:0] su_dec;
  logic                 su_active;

  logic                 is_step, produces, out_free, advance;
  logic                 is_last;
  logic signed [PW-1:0] maj_inc, px, py;
  logic signed [DW-1:0] dec_next;

  lr_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .start_x_i    (in_sx_q),
    .start_y_i    (in_sy_q),
    .end_x_i      (in_ex_q),
    .end_y_i      (in_ey_q),
    .octant_o     (su_oct),
    .major_pos_o  (su_maj_pos),
    .major_end_o  (su_maj_end),
    .minor_pos_o  (su_min_pos),
    .delta_major_o(su_dmaj),
    .delta_minor_o(su_dmin),
    .decision_o   (su_dec),
    .active_o     (su_active)
  );

  assign is_step  = (in_op_q == OP_STEP);
  assign produces = is_step && active_q;
  assign out_free = !out_valid_q || pix_o.ready;
  assign advance  = in_valid_q && (!produces || out_free);

  assign req_i.ready = !in_valid_q || advance;

  always_comb begin
    maj_inc = major_pos_q + PW'(1);
    is_last = (maj_inc == major_end_q);
    case (octant_q)
      OCT_0: begin px = major_pos_q;  py = minor_pos_q;  end
      OCT_1: begin px = minor_pos_q;  py = major_pos_q;  end
      OCT_2: begin px = -minor_pos_q; py = major_pos_q;  end
      OCT_3: begin px = -major_pos_q; py = minor_pos_q;  end
      OCT_4: begin px = -major_pos_q; py = -minor_pos_q; end
      OCT_5: begin px = -minor_pos_q; py = -major_pos_q; end
      OCT_6: begin px = minor_pos_q;  py = -major_pos_q; end
      default: begin px = major_pos_q; py = -minor_pos_q; end
    endcase
    dec_next = decision_q
               - (decision_q[DW-1] ? DW'(0)
                                   : $signed({{(DW-PW){delta_major_q[PW-1]}}, delta_major_q}))
               + $signed({{(DW-PW){delta_minor_q[PW-1]}}, delta_minor_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_op_q <= opcode_e'(req_i.opcode);
      in_sx_q <= req_i.start_x;
      in_sy_q <= req_i.start_y;
      in_ex_q <= req_i.end_x;
      in_ey_q <= req_i.end_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octant_q      <= OCT_0;
      major_pos_q   <= '0;
      major_end_q   <= '0;
      minor_pos_q   <= '0;
      delta_major_q <= '0;
      delta_minor_q <= '0;
      decision_q    <= '0;
      active_q      <= 1'b0;
    end else if (advance) begin
      if (!is_step) begin
        octant_q      <= su_oct;
        major_pos_q   <= su_maj_pos;
        major_end_q   <= su_maj_end;
        minor_pos_q   <= su_min_pos;
        delta_major_q <= su_dmaj;
        delta_minor_q <= su_dmin;
        decision_q    <= su_dec;
        active_q      <= su_active;
      end else if (active_q) begin
        major_pos_q <= maj_inc;
        if (!decision_q[DW-1]) begin
          minor_pos_q <= minor_pos_q + PW'(1);
        end
        decision_q <= dec_next;
        if (is_last) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && produces) begin
      out_valid_q <= 1'b1;
    end else if (pix_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produces) begin
      out_x_q    <= px[COORD_BITS-1:0];
      out_y_q    <= py[COORD_BITS-1:0];
      out_last_q <= is_last;
    end
  end

  assign pix_o.valid   = out_valid_q;
  assign pix_o.pixel_x = out_x_q;
  assign pix_o.pixel_y = out_y_q;
  assign pix_o.last    = out_last_q;

  `LR_ASSERT_SAME(a_pos_before_end, active_q, major_pos_q < major_end_q,
                  "Active line has no pixels left.")
  `LR_ASSERT_SAME(a_minor_in_range, active_q,
                  (delta_minor_q >= 0) && (delta_minor_q <= delta_major_q),
                  "Minor delta outside the first octant.")
  `LR_ASSERT_SAME(a_decision_bounded, active_q,
                  ($signed({{(DW-PW){1'b0}}, delta_major_q}) >= decision_q) &&
                  (decision_q >= -$signed({{(DW-PW){1'b0}}, delta_major_q})),
                  "Decision term out of range.")
  `LR_ASSERT_NEXT(a_idle_step_silent, advance && is_step && !active_q && !out_valid_q,
                  !out_valid_q, "Step without a line produced a pixel.")

endmodule

>>> bench/tb.sv
// Self-checking testbench for the Bresenham line rasterizer with random handshake stalls.
`timescale 1ns / 100ps

module tb;
  import lr_pkg::*;

  localparam int unsigned COORD_BITS = 11;
  localparam int          COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int          TARGET_REQUESTS = 1450;
  localparam int          IDLE_LIMIT = 5000;
  localparam int          HOLD_START = 800;
  localparam int          HOLD_CYCLES = 600;
  localparam int          TAIL_CYCLES = 8;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } pixel_t;

  class bresenham_tracker;
    octant_e octant;
    int      major_pos;
    int      major_end;
    int      minor_pos;
    int      decision;
    int      delta_major;
    int      delta_minor;
    bit      active;
    pixel_t  expected_pixels[$];
    int      errors;

    function new();
      octant      = OCT_0;
      major_pos   = 0;
      major_end   = 0;
      minor_pos   = 0;
      decision    = 0;
      delta_major = 0;
      delta_minor = 0;
      active      = 1'b0;
      errors      = 0;
    endfunction

    function void fold(octant_e oct, int x, int y, output int maj, output int mnr);
      case (oct)
        OCT_0: begin maj = x;  mnr = y;  end
        OCT_1: begin maj = y;  mnr = x;  end
        OCT_2: begin maj = y;  mnr = -x; end
        OCT_3: begin maj = -x; mnr = y;  end
        OCT_4: begin maj = -x; mnr = -y; end
        OCT_5: begin maj = -y; mnr = -x; end
        OCT_6: begin maj = -y; mnr = x;  end
        default: begin maj = x; mnr = -y; end
      endcase
    endfunction

    function void unfold(octant_e oct, int maj, int mnr, output int x, output int y);
      case (oct)
        OCT_0: begin x = maj;  y = mnr;  end
        OCT_1: begin x = mnr;  y = maj;  end
        OCT_2: begin x = -mnr; y = maj;  end
        OCT_3: begin x = -maj; y = mnr;  end
        OCT_4: begin x = -maj; y = -mnr; end
        OCT_5: begin x = -mnr; y = -maj; end
        OCT_6: begin x = mnr;  y = -maj; end
        default: begin x = maj; y = -mnr; end
      endcase
    endfunction

    function void note_request(opcode_e op, logic [COORD_BITS-1:0] sx,
                               logic [COORD_BITS-1:0] sy, logic [COORD_BITS-1:0] ex,
                               logic [COORD_BITS-1:0] ey);
      int     dx;
      int     dy;
      int     minor_end;
      int     px;
      int     py;
      bit     steep;
      pixel_t pix;
      if (op == OP_START) begin
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        steep = ((dx < 0) ? -dx : dx) <= ((dy < 0) ? -dy : dy);
        if (dx >= 0 && dy >= 0) begin
          octant = steep ? OCT_1 : OCT_0;
        end else if (dx < 0 && dy >= 0) begin
          octant = steep ? OCT_2 : OCT_3;
        end else if (dx < 0) begin
          octant = steep ? OCT_5 : OCT_4;
        end else begin
          octant = steep ? OCT_6 : OCT_7;
        end
        fold(octant, int'(sx), int'(sy), major_pos, minor_pos);
        fold(octant, int'(ex), int'(ey), major_end, minor_end);
        delta_major = major_end - major_pos;
        delta_minor = minor_end - minor_pos;
        decision    = 2 * delta_minor - delta_major;
        active      = delta_major > 0;
      end else if (active) begin
        unfold(octant, major_pos, minor_pos, px, py);
        pix.x    = px[COORD_BITS-1:0];
        pix.y    = py[COORD_BITS-1:0];
        pix.last = (major_pos + 1) == major_end;
        expected_pixels.push_back(pix);
        if (decision >= 0) begin
          minor_pos += 1;
          decision  -= delta_major;
        end
        decision  += delta_minor;
        major_pos += 1;
        if (pix.last) begin
          active = 1'b0;
        end
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d last=%0d",
                 $time, got.x, got.y, got.last);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: pixel_x mismatch, expected %0d, actual %0d", $time, want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t: pixel_y mismatch, expected %0d, actual %0d", $time, want.y, got.y);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last mismatch, expected %0d, actual %0d", $time, want.last,
                   got.last);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  lr_req_if #(.COORD_BITS(COORD_BITS)) req_if ();
  lr_pix_if #(.COORD_BITS(COORD_BITS)) pix_if ();

  line_rasterizer #(
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .pix_o (pix_if)
  );

  bresenham_tracker tracker;
  int               requests_sent;
  int               burst_left;
  bit               drained_once;

  always #5 clk_i = ~clk_i;

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  function automatic int line_length(int sx, int sy, int ex, int ey);
    int adx;
    int ady;
    adx = (ex > sx) ? ex - sx : sx - ex;
    ady = (ey > sy) ? ey - sy : sy - ey;
    return (adx > ady) ? adx : ady;
  endfunction

  task automatic send_request(opcode_e op, int sx, int sy, int ex, int ey);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    req_if.valid   <= 1'b1;
    req_if.opcode  <= op;
    req_if.start_x <= sx[COORD_BITS-1:0];
    req_if.start_y <= sy[COORD_BITS-1:0];
    req_if.end_x   <= ex[COORD_BITS-1:0];
    req_if.end_y   <= ey[COORD_BITS-1:0];
    do @(posedge clk_i); while (!req_if.ready);
    tracker.note_request(op, sx[COORD_BITS-1:0], sy[COORD_BITS-1:0], ex[COORD_BITS-1:0],
                         ey[COORD_BITS-1:0]);
    requests_sent++;
  endtask

  task automatic send_steps(int count);
    repeat (count) begin
      send_request(OP_STEP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    end
  endtask

  task automatic draw_line(int sx, int sy, int ex, int ey, int steps);
    send_request(OP_START, sx, sy, ex, ey);
    send_steps(steps);
  endtask

  task automatic drain_pixels();
    req_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (tracker.expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    int dir_x[8] = '{1, 1, -1, -1, -2, -1, 0, 2};
    int dir_y[8] = '{0, 1, 1, 0, -1, -1, -1, -1};
    send_steps(1);
    draw_line(COORD_MAX, 0, COORD_MAX, 0, 1);
    for (int i = 0; i < 8; i++) begin
      draw_line(1024, 1024, 1024 + dir_x[i], 1024 + dir_y[i],
                line_length(0, 0, dir_x[i], dir_y[i]));
    end
    draw_line(0, 0, COORD_MAX, COORD_MAX, 1);
    draw_line(COORD_MAX, 0, 0, COORD_MAX, 1);
  endtask

  task automatic run_random();
    int kind;
    int span;
    int sx;
    int sy;
    int ex;
    int ey;
    int len;
    while (requests_sent < TARGET_REQUESTS) begin
      if (!drained_once && requests_sent >= TARGET_REQUESTS / 2) begin
        drained_once = 1'b1;
        drain_pixels();
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        span = ($urandom_range(0, 9) == 0) ? 80 : 12;
        sx   = $urandom_range(0, COORD_MAX);
        sy   = $urandom_range(0, COORD_MAX);
        ex   = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
        ey   = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
        len  = line_length(sx, sy, ex, ey);
        if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(0, len);
        end else if ($urandom_range(0, 9) < 3) begin
          len += $urandom_range(1, 2);
        end
        draw_line(sx, sy, ex, ey, len);
      end else if (kind < 85) begin
        draw_line($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  $urandom_range(0, 30));
      end else if (kind < 95) begin
        send_steps($urandom_range(1, 3));
      end else begin
        draw_line($urandom_range(0, 1) ? COORD_MAX : 0, $urandom_range(0, 1) ? COORD_MAX : 0,
                  $urandom_range(0, 1) ? COORD_MAX : 0, $urandom_range(0, 1) ? COORD_MAX : 0,
                  $urandom_range(0, 8));
      end
    end
  endtask

  initial begin
    tracker        = new();
    requests_sent  = 0;
    burst_left     = 0;
    drained_once   = 1'b0;
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.opcode  <= OP_START;
    req_if.start_x <= '0;
    req_if.start_y <= '0;
    req_if.end_x   <= '0;
    req_if.end_y   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_random();
    drain_pixels();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.expected_pixels.size() != 0) begin
      $display("%0t: %0d expected pixels never arrived", $time,
               tracker.expected_pixels.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int     cycle;
    int     hold;
    int     mode;
    int     mode_left;
    pixel_t got;
    cycle     = 0;
    hold      = 0;
    mode      = 0;
    mode_left = 0;
    pix_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pix_if.valid && pix_if.ready) begin
        got.x    = pix_if.pixel_x;
        got.y    = pix_if.pixel_y;
        got.last = pix_if.last;
        tracker.check_pixel(got);
      end
      cycle++;
      if (cycle == HOLD_START) begin
        hold = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      if (hold > 0) begin
        hold--;
        pix_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: pix_if.ready <= 1'b1;
          1: pix_if.ready <= 1'($urandom_range(0, 1));
          2: pix_if.ready <= ($urandom_range(0, 99) < 85);
          default: pix_if.ready <= cycle[2];
        endcase
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (pix_if.valid && pix_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no request or pixel moved for %0d cycles", $time, IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

endmodule
